@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tpca_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpca_pkg
// Shared constants and types of the token pair counter.
// ----------------------------------------------------------------------------
package tpca_pkg;

  localparam int TOKEN_BITS  = 8;
  localparam int COUNT_BITS  = 20;
  localparam int PAIR_BITS   = 2 * TOKEN_BITS;
  localparam int PAIR_DEPTH  = 1 << PAIR_BITS;
  localparam int EPOCH_BITS  = 8;

  localparam int IN_TOKEN_W  = 8;
  localparam int OUT_TOKEN_W = 8;
  localparam int OUT_COUNT_W = 20;
  localparam int MERGE_MIN   = 2;

  localparam int OUTQ_DEPTH    = 4;
  localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } tpca_state_t;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [COUNT_BITS-1:0] cnt;
  } tpca_word_t;

  typedef struct packed {
    logic                   worth_merging;
    logic [OUT_COUNT_W-1:0] best_count;
    logic [OUT_TOKEN_W-1:0] best_second;
    logic [OUT_TOKEN_W-1:0] best_first;
    logic                   found;
  } tpca_result_t;

endpackage
`default_nettype wire

@@ sv/tpca_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpca_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tpca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/tpca_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpca_outq
// Small result queue between the count pipeline and the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpca_outq
  import tpca_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire tpca_result_t             push_data,
  input  wire logic                     pop,
  output logic                          q_valid,
  output tpca_result_t                  q_data,
  output logic      [OUTQ_CNT_BITS-1:0] q_count
);

  tpca_result_t             slot_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_BITS-1:0] wptr_r, wptr_nxt;
  logic [OUTQ_PTR_BITS-1:0] rptr_r, rptr_nxt;
  logic [OUTQ_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                     do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wptr_nxt = push   ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + OUTQ_CNT_BITS'(push) - OUTQ_CNT_BITS'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_data  = slot_r[rptr_r];
  assign q_count = cnt_r;

  `ASSERT_IMP(a_no_overflow, push, cnt_r != OUTQ_CNT_BITS'(OUTQ_DEPTH) || do_pop,
              "result queue overflow")

endmodule
`default_nettype wire

@@ sv/token_pair_count_argmax.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// token_pair_count_argmax
// Adjacent token pair counter with most frequent pair report per sequence.
// ----------------------------------------------------------------------------
// Takes one token item per cycle. Each adjacent pair bumps a saturating count
// in a 64K-entry RAM through a two-stage read-modify-write loop (read, then
// update and write back); a repeat of the pair just written is forwarded, so
// back-to-back items never stall. The running best pair is tracked in the
// update stage and the result for a sequence is queued in the cycle after
// its last item is taken, in a four-entry result queue. Counts are tagged
// with an 8-bit sequence epoch instead of being cleared; after reset and
// after every 255th sequence the block runs a clearing pass over the RAM,
// one entry per cycle, during which in_tready is low. Input is also held
// off while the result queue, counting a result being pushed, is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module token_pair_count_argmax
  import tpca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] token_id
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // [0] found, [8:1] best_first,
                                       // [16:9] best_second, [36:17] best_count,
                                       // [37] worth_merging, [39:38] zero
);

  tpca_state_t state_r, state_nxt;
  logic [PAIR_BITS-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic run, sweep_we, sweep_done;

  logic [EPOCH_BITS-1:0] epoch_r, epoch_nxt;
  logic [TOKEN_BITS-1:0] prev_token_r;
  logic                  have_prev_r;
  logic [TOKEN_BITS-1:0] tok;
  logic                  accept;

  logic                 s1_valid_r, s1_pair_r, s1_last_r;
  logic [PAIR_BITS-1:0] s1_addr_r;

  logic                 wr_valid_r;
  logic [PAIR_BITS-1:0] wr_addr_r;
  tpca_word_t           wr_word_r;

  logic [COUNT_BITS-1:0] top_count_r, top_count_nxt;
  logic [PAIR_BITS-1:0]  top_pair_r, top_pair_nxt;

  tpca_word_t           ram_rdata, ram_wdata, cur_word, upd_word;
  logic                 ram_we, upd_we;
  logic [PAIR_BITS-1:0] ram_waddr, ram_raddr;

  logic [COUNT_BITS-1:0] cur_cnt, new_cnt, fin_cnt;
  logic [PAIR_BITS-1:0]  fin_pair;
  logic                  beats;
  logic                  res_push;
  tpca_result_t          res, q_data;
  logic [OUTQ_CNT_BITS-1:0] q_count;
  logic [OUTQ_CNT_BITS:0]   q_need;

  // control
  assign sweep_done = (sweep_cnt_r == {PAIR_BITS{1'b1}});
  assign res_push   = s1_valid_r && s1_last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (res_push && (epoch_r == EPOCH_LAST)) begin
          state_nxt = ST_SWEEP;
        end
      end
      default: state_nxt = ST_SWEEP;
    endcase
  end

  always_comb begin
    run      = 1'b0;
    sweep_we = 1'b0;
    case (state_r)
      ST_SWEEP: sweep_we = 1'b1;
      ST_RUN:   run      = 1'b1;
      default: begin
        run      = 1'b0;
        sweep_we = 1'b0;
      end
    endcase
  end

  assign sweep_cnt_nxt = sweep_we ? sweep_cnt_r + 1'b1 : '0;

  assign q_need    = {1'b0, q_count} + (OUTQ_CNT_BITS + 1)'(res_push);
  assign in_tready = run && (q_need < (OUTQ_CNT_BITS + 1)'(OUTQ_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign tok       = TOKEN_BITS'(in_tdata[IN_TOKEN_W-1:0]);

  assign epoch_nxt = !res_push ? epoch_r :
                     (epoch_r == EPOCH_LAST) ? EPOCH_FIRST : epoch_r + 1'b1;

  // read stage
  assign ram_raddr = {prev_token_r, tok};

  // update stage
  assign cur_word = (wr_valid_r && (wr_addr_r == s1_addr_r)) ? wr_word_r : ram_rdata;
  assign cur_cnt  = (cur_word.tag == epoch_r) ? cur_word.cnt : '0;
  assign new_cnt  = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign beats    = {new_cnt, s1_addr_r} > {top_count_r, top_pair_r};
  assign upd_we   = run && s1_valid_r && s1_pair_r;

  always_comb begin
    upd_word.tag = epoch_r;
    upd_word.cnt = new_cnt;
  end

  always_comb begin
    fin_cnt  = top_count_r;
    fin_pair = top_pair_r;
    if (s1_valid_r && s1_pair_r && beats) begin
      fin_cnt  = new_cnt;
      fin_pair = s1_addr_r;
    end
    top_count_nxt = res_push ? '0 : fin_cnt;
    top_pair_nxt  = res_push ? '0 : fin_pair;
  end

  always_comb begin
    res.found         = (fin_cnt != '0);
    res.best_first    = OUT_TOKEN_W'(fin_pair[PAIR_BITS-1:TOKEN_BITS]);
    res.best_second   = OUT_TOKEN_W'(fin_pair[TOKEN_BITS-1:0]);
    res.best_count    = OUT_COUNT_W'(fin_cnt);
    res.worth_merging = (fin_cnt >= COUNT_BITS'(MERGE_MIN));
  end

  assign ram_we    = sweep_we || upd_we;
  assign ram_waddr = sweep_we ? sweep_cnt_r : s1_addr_r;
  assign ram_wdata = sweep_we ? tpca_word_t'('0) : upd_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
      epoch_r     <= EPOCH_FIRST;
      prev_token_r <= '0;
      have_prev_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      wr_valid_r  <= 1'b0;
      top_count_r <= '0;
      top_pair_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      epoch_r     <= epoch_nxt;
      if (accept) begin
        prev_token_r <= tok;
        have_prev_r  <= !in_tlast;
      end
      s1_valid_r  <= accept;
      wr_valid_r  <= upd_we;
      top_count_r <= top_count_nxt;
      top_pair_r  <= top_pair_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pair_r <= have_prev_r;
    s1_last_r <= in_tlast;
    s1_addr_r <= ram_raddr;
    wr_addr_r <= s1_addr_r;
    wr_word_r <= upd_word;
  end

  tpca_ram #(
    .WIDTH ($bits(tpca_word_t)),
    .DEPTH (PAIR_DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tpca_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .pop       (out_tready),
    .q_valid   (out_tvalid),
    .q_data    (q_data),
    .q_count   (q_count)
  );

  assign out_tdata = {2'b00, q_data.worth_merging, q_data.best_count,
                      q_data.best_second, q_data.best_first, q_data.found};

  `ASSERT_IMP(a_epoch_live, 1'b1, epoch_r != '0, "epoch reached the swept tag")
  `ASSERT_NXT(a_top_cleared, res_push, top_count_r == '0 && top_pair_r == '0,
              "best pair not cleared after sequence end")
  `ASSERT_IMP(a_no_wrap, upd_we, upd_word.cnt != '0, "pair count wrapped")
  `ASSERT_IMP(a_sweep_quiet, sweep_we, !upd_we, "pair update during clearing pass")

endmodule
`default_nettype wire
